// ===== rtl/htfd_pkg.sv =====
// htfd_pkg: item types, result kind codes, phase codes and the hex digit helper
// shared by the hex text frame decoder modules
// no dependencies
package htfd_pkg;

    localparam int CNT_W   = 8;   // holds any frame byte limit up to 255
    localparam int Q_DEPTH = 4;   // result queue entries
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // result kinds
    localparam logic [2:0] KIND_DATA     = 3'd0;
    localparam logic [2:0] KIND_DONE     = 3'd1;
    localparam logic [2:0] KIND_BAD      = 3'd2;
    localparam logic [2:0] KIND_UNTERM   = 3'd3;
    localparam logic [2:0] KIND_OVERFLOW = 3'd4;

    // frame phases
    localparam logic [1:0] PH_AWAIT  = 2'd0;
    localparam logic [1:0] PH_FRAME  = 2'd1;
    localparam logic [1:0] PH_IGNORE = 2'd2;

    // characters
    localparam logic [7:0] CH_OPEN  = 8'h5B;  // '['
    localparam logic [7:0] CH_CLOSE = 8'h5D;  // ']'
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;

    typedef struct packed {
        logic [7:0] character;
        logic       buffer_end;
    } in_item_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] byte_value;
        logic [5:0] frame_length;
        logic       last_of_run;
    } out_item_t;

    // results of one input item, first entry always used first
    typedef struct packed {
        logic [1:0] num;
        out_item_t  item0;
        out_item_t  item1;
    } dec_res_t;

    // {is_hex, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                d = c - CH_ZERO;
                hex_digit = {1'b1, d[3:0]};
            end else if (c >= CH_UA && c <= CH_UF) begin
                d = c - CH_UA + 8'd10;
                hex_digit = {1'b1, d[3:0]};
            end else if (c >= CH_LA && c <= CH_LF) begin
                d = c - CH_LA + 8'd10;
                hex_digit = {1'b1, d[3:0]};
            end else begin
                hex_digit = 5'd0;
            end
        end
    endfunction

endpackage

// ===== rtl/htfd_decode.sv =====
// htfd_decode: frame state registers and the per-character decode logic
// depends on htfd_pkg
module htfd_decode #(
    parameter int MAX_FRAME_BYTES = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               take,
    input  htfd_pkg::in_item_t item,
    output htfd_pkg::dec_res_t res
);

    logic [1:0]                   phase_reg, phase_next;
    logic [3:0]                   hd_reg, hd_next;
    logic                         dp_reg, dp_next;
    logic [htfd_pkg::CNT_W-1:0]   cnt_reg, cnt_next;

    logic                         e0_valid, e1_valid;
    logic [2:0]                   e0_kind;
    logic [7:0]                   e0_val;
    logic [htfd_pkg::CNT_W-1:0]   e0_len, e1_len;
    logic [4:0]                   hx;
    htfd_pkg::out_item_t          o0, o1;

    always_comb begin
        phase_next = phase_reg;
        hd_next    = hd_reg;
        dp_next    = dp_reg;
        cnt_next   = cnt_reg;
        e0_valid   = 1'b0;
        e0_kind    = htfd_pkg::KIND_DATA;
        e0_val     = 8'd0;
        e0_len     = '0;
        hx         = htfd_pkg::hex_digit(item.character);

        unique case (phase_reg)
            htfd_pkg::PH_AWAIT: begin
                if (item.character == htfd_pkg::CH_OPEN) begin
                    phase_next = htfd_pkg::PH_FRAME;
                    hd_next    = 4'd0;
                    dp_next    = 1'b0;
                    cnt_next   = '0;
                end else begin
                    e0_valid   = 1'b1;
                    e0_kind    = htfd_pkg::KIND_BAD;
                    phase_next = htfd_pkg::PH_IGNORE;
                end
            end
            htfd_pkg::PH_FRAME: begin
                if (hx[4]) begin
                    if (dp_reg) begin
                        dp_next  = 1'b0;
                        e0_valid = 1'b1;
                        if (cnt_reg >= htfd_pkg::CNT_W'(MAX_FRAME_BYTES)) begin
                            e0_kind    = htfd_pkg::KIND_OVERFLOW;
                            e0_len     = cnt_reg;
                            phase_next = htfd_pkg::PH_IGNORE;
                        end else begin
                            cnt_next = cnt_reg + htfd_pkg::CNT_W'(1);
                            e0_kind  = htfd_pkg::KIND_DATA;
                            e0_val   = {hd_reg, hx[3:0]};
                            e0_len   = cnt_reg + htfd_pkg::CNT_W'(1);
                        end
                    end else begin
                        hd_next = hx[3:0];
                        dp_next = 1'b1;
                    end
                end else if (item.character == htfd_pkg::CH_SPACE) begin
                    // skipped
                end else if (item.character == htfd_pkg::CH_CLOSE) begin
                    e0_valid   = 1'b1;
                    e0_kind    = htfd_pkg::KIND_DONE;
                    e0_len     = cnt_reg;
                    phase_next = htfd_pkg::PH_IGNORE;
                end else begin
                    e0_valid   = 1'b1;
                    e0_kind    = htfd_pkg::KIND_BAD;
                    e0_len     = cnt_reg;
                    phase_next = htfd_pkg::PH_IGNORE;
                end
            end
            default: begin
                // ignoring the rest of the buffer
            end
        endcase

        // end of buffer inside an open frame
        e1_valid = item.buffer_end && (phase_next == htfd_pkg::PH_FRAME);
        e1_len   = cnt_next;
        if (item.buffer_end) begin
            phase_next = htfd_pkg::PH_AWAIT;
            hd_next    = 4'd0;
            dp_next    = 1'b0;
            cnt_next   = '0;
        end
    end

    always_comb begin
        o0.kind         = e0_kind;
        o0.byte_value   = e0_val;
        o0.frame_length = e0_len[5:0];
        o0.last_of_run  = !e1_valid;
        o1.kind         = htfd_pkg::KIND_UNTERM;
        o1.byte_value   = 8'd0;
        o1.frame_length = e1_len[5:0];
        o1.last_of_run  = 1'b1;
        priority if (e0_valid && e1_valid) begin
            res.num   = 2'd2;
            res.item0 = o0;
            res.item1 = o1;
        end else if (e1_valid) begin
            res.num   = 2'd1;
            res.item0 = o1;
            res.item1 = o1;
        end else begin
            res.num   = {1'b0, e0_valid};
            res.item0 = o0;
            res.item1 = o1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= htfd_pkg::PH_AWAIT;
            hd_reg    <= 4'd0;
            dp_reg    <= 1'b0;
            cnt_reg   <= '0;
        end else if (take) begin
            phase_reg <= phase_next;
            hd_reg    <= hd_next;
            dp_reg    <= dp_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        take && item.buffer_end |=> phase_reg == htfd_pkg::PH_AWAIT && cnt_reg == '0
                                    && !dp_reg)
        else $error("buffer end did not return decoder to awaiting start");

    a_cnt_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= htfd_pkg::CNT_W'(MAX_FRAME_BYTES))
        else $error("byte count beyond frame limit");

endmodule

// ===== rtl/htfd_outq.sv =====
// htfd_outq: four-entry result queue, takes up to two results per cycle, gives one
// depends on htfd_pkg
module htfd_outq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_en,
    input  htfd_pkg::dec_res_t  res,
    output logic                room,
    output logic                m_valid,
    input  logic                m_ready,
    output htfd_pkg::out_item_t m_data
);

    htfd_pkg::out_item_t              q_reg [htfd_pkg::Q_DEPTH];
    logic [htfd_pkg::Q_PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [htfd_pkg::Q_CNT_W-1:0]     count_reg, count_next;
    logic [htfd_pkg::Q_CNT_W-1:0]     push_n;
    logic                             pop;

    assign push_n  = wr_en ? htfd_pkg::Q_CNT_W'(res.num) : '0;
    assign pop     = m_valid && m_ready;
    assign m_valid = count_reg != '0;
    assign m_data  = q_reg[rd_ptr_reg];
    // room for the worst case of two results
    assign room    = count_reg <= htfd_pkg::Q_CNT_W'(htfd_pkg::Q_DEPTH - 2);
    assign count_next = count_reg + push_n - htfd_pkg::Q_CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (wr_en && res.num != 2'd0) begin
            q_reg[wr_ptr_reg] <= res.item0;
        end
        if (wr_en && res.num == 2'd2) begin
            q_reg[wr_ptr_reg + htfd_pkg::Q_PTR_W'(1)] <= res.item1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + htfd_pkg::Q_PTR_W'(push_n);
            rd_ptr_reg <= rd_ptr_reg + htfd_pkg::Q_PTR_W'(pop);
            count_reg  <= count_next;
        end
    end

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> count_reg <= htfd_pkg::Q_CNT_W'(htfd_pkg::Q_DEPTH - 2))
        else $error("result queue written without room");

    a_count_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= htfd_pkg::Q_CNT_W'(htfd_pkg::Q_DEPTH)
        && wr_ptr_reg == rd_ptr_reg + htfd_pkg::Q_PTR_W'(count_reg))
        else $error("result queue pointers and count disagree");

endmodule

// ===== rtl/hex_text_frame_decoder.sv =====
// hex_text_frame_decoder: top level, decodes bracketed hex text frames into bytes
// depends on htfd_pkg, htfd_decode, htfd_outq
//
//   channel  dir  handshake          payload
//   s_       in   s_valid / s_ready  htfd_pkg::in_item_t  (character, buffer_end)
//   m_       out  m_valid / m_ready  htfd_pkg::out_item_t (kind, byte_value,
//                                    frame_length, last_of_run)
//
// one character is decoded in the cycle it is accepted, results land in a
// four-entry queue and show on m_ the next cycle when no older results are queued
// s_ready is high while the queue has room for two results, so a character
// is taken every cycle as long as results drain at one per cycle
// a character that causes two results (end of buffer inside a frame) costs
// two output transfers, the queue output port sets the sustained rate
// aresetn is synchronous, clears frame state and the queue; no results pending
module hex_text_frame_decoder #(
    parameter int MAX_FRAME_BYTES = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  htfd_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output htfd_pkg::out_item_t m_data
);

    logic               take;
    htfd_pkg::dec_res_t res;
    logic               room;

    // accept only with space for the worst-case pair of results
    assign s_ready = room;
    assign take    = s_valid && s_ready;

    htfd_decode #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .item    (s_data),
        .res     (res)
    );

    htfd_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (take),
        .res     (res),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== dv/hex_text_frame_decoder_test.sv =====
// hex_text_frame_decoder_test: self-checking testbench for the hex text frame decoder
// drives receive buffers of characters and checks every result against a local decoder
// depends on htfd_pkg and hex_text_frame_decoder
module hex_text_frame_decoder_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_FRAME_BYTES = 32;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_CYCLES     = 250;
    localparam int HOLD_AT_ITEM    = 60;
    localparam int MODE_ITEMS      = 170;

    // buffer shapes for the random part
    typedef enum int {
        SHAPE_GOOD,      // closed frame
        SHAPE_HALF,      // closed frame with a dangling digit
        SHAPE_BADCHAR,   // frame aborted by a stray character
        SHAPE_OPEN_END,  // buffer ends inside the frame
        SHAPE_NOISE,     // random characters
        SHAPE_LONG       // frame near or past the byte limit
    } buf_shape_t;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    htfd_pkg::in_item_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    htfd_pkg::out_item_t m_data;

    hex_text_frame_decoder #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 12 ns clock
    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // stimulus and scoreboard storage
    htfd_pkg::in_item_t  tx_chars[$];       // items waiting to be offered
    logic [7:0]          buf_text[$];       // buffer under construction
    htfd_pkg::out_item_t due_results[$];    // results the decoder owes, oldest first
    int                  total_chars  = 0;
    int                  mode_edge1   = 0;
    int                  mode_edge2   = 0;
    int                  in_count     = 0;  // items accepted on s_
    int                  err_count    = 0;
    int                  cycle_count  = 0;
    int                  hold_left    = 0;
    logic                hold_done    = 1'b0;
    htfd_pkg::out_item_t want;

    // local decoder state
    logic [1:0] frame_phase;
    logic [3:0] pend_digit;
    logic       digit_held;
    int         byte_total;

    // value of a hex digit in either case, -1 for anything else
    function automatic int digit_value(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return int'(c) - 48;
        if (c >= 8'h41 && c <= 8'h46)
            return int'(c) - 65 + 10;
        if (c >= 8'h61 && c <= 8'h66)
            return int'(c) - 97 + 10;
        return -1;
    endfunction

    function automatic htfd_pkg::out_item_t result_of(input logic [2:0] kind,
                                                      input logic [7:0] val,
                                                      input int len);
        htfd_pkg::out_item_t r;
        r.kind         = kind;
        r.byte_value   = val;
        r.frame_length = 6'(len);
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    function automatic void clear_frame();
        pend_digit = 4'd0;
        digit_held = 1'b0;
        byte_total = 0;
    endfunction

    // work out the results of one accepted character and queue them
    task automatic decode_char(input htfd_pkg::in_item_t it);
        htfd_pkg::out_item_t res[2];
        int                  n;
        int                  h;
        n = 0;
        h = digit_value(it.character);
        if (frame_phase == htfd_pkg::PH_AWAIT) begin
            if (it.character == htfd_pkg::CH_OPEN) begin
                frame_phase = htfd_pkg::PH_FRAME;
                clear_frame();
            end else begin
                res[n] = result_of(htfd_pkg::KIND_BAD, 8'd0, 0);
                n++;
                frame_phase = htfd_pkg::PH_IGNORE;
            end
        end else if (frame_phase == htfd_pkg::PH_FRAME) begin
            if (h >= 0) begin
                if (digit_held) begin
                    digit_held = 1'b0;
                    // a byte past the limit is swallowed and the frame dies
                    if (byte_total >= MAX_FRAME_BYTES) begin
                        res[n] = result_of(htfd_pkg::KIND_OVERFLOW, 8'd0, byte_total);
                        n++;
                        frame_phase = htfd_pkg::PH_IGNORE;
                    end else begin
                        byte_total++;
                        res[n] = result_of(htfd_pkg::KIND_DATA, {pend_digit, 4'(h)},
                                           byte_total);
                        n++;
                    end
                end else begin
                    pend_digit = 4'(h);
                    digit_held = 1'b1;
                end
            end else if (it.character == htfd_pkg::CH_CLOSE) begin
                // a dangling digit is simply dropped here
                res[n] = result_of(htfd_pkg::KIND_DONE, 8'd0, byte_total);
                n++;
                frame_phase = htfd_pkg::PH_IGNORE;
            end else if (it.character != htfd_pkg::CH_SPACE) begin
                res[n] = result_of(htfd_pkg::KIND_BAD, 8'd0, byte_total);
                n++;
                frame_phase = htfd_pkg::PH_IGNORE;
            end
        end
        if (it.buffer_end) begin
            if (frame_phase == htfd_pkg::PH_FRAME) begin
                res[n] = result_of(htfd_pkg::KIND_UNTERM, 8'd0, byte_total);
                n++;
            end
            frame_phase = htfd_pkg::PH_AWAIT;
            clear_frame();
        end
        if (n > 0)
            res[n - 1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++)
            due_results.push_back(res[i]);
    endtask

    // ---------------- stimulus construction ----------------

    // hex digit in random case, sometimes preceded by spaces
    task automatic add_digit(input logic [3:0] nib);
        repeat ($urandom_range(3) == 0 ? $urandom_range(2, 1) : 0)
            buf_text.push_back(htfd_pkg::CH_SPACE);
        if (nib < 4'd10)
            buf_text.push_back(htfd_pkg::CH_ZERO + 8'(nib));
        else if ($urandom_range(1) == 1)
            buf_text.push_back(htfd_pkg::CH_UA + 8'(nib) - 8'd10);
        else
            buf_text.push_back(htfd_pkg::CH_LA + 8'(nib) - 8'd10);
    endtask

    function automatic logic [7:0] stray_char();
        logic [7:0] c;
        do
            c = 8'($urandom);
        while (digit_value(c) >= 0 || c == htfd_pkg::CH_SPACE || c == htfd_pkg::CH_CLOSE);
        return c;
    endfunction

    // move the buffer under construction to the send queue, end flag on its last item
    task automatic flush_buffer();
        htfd_pkg::in_item_t it;
        foreach (buf_text[i]) begin
            it.character  = buf_text[i];
            it.buffer_end = (i == buf_text.size() - 1);
            tx_chars.push_back(it);
        end
        buf_text.delete();
    endtask

    task automatic add_text(input string s, input logic [7:0] tail = 8'h00,
                            input logic use_tail = 1'b0);
        for (int i = 0; i < s.len(); i++)
            buf_text.push_back(s[i]);
        if (use_tail)
            buf_text.push_back(tail);
        flush_buffer();
    endtask

    task automatic add_buffer(input buf_shape_t shape, input int nbytes);
        logic [7:0] b;
        if (shape == SHAPE_NOISE) begin
            repeat ($urandom_range(4, 1))
                buf_text.push_back(8'($urandom));
        end else begin
            buf_text.push_back(htfd_pkg::CH_OPEN);
            repeat (nbytes) begin
                b = 8'($urandom);
                add_digit(b[7:4]);
                add_digit(b[3:0]);
            end
            case (shape)
                SHAPE_HALF: begin
                    add_digit(4'($urandom));
                    buf_text.push_back(htfd_pkg::CH_CLOSE);
                end
                SHAPE_BADCHAR: begin
                    if ($urandom_range(1) == 1)
                        add_digit(4'($urandom));
                    buf_text.push_back(stray_char());
                end
                SHAPE_OPEN_END: begin
                    if ($urandom_range(2) == 0)
                        add_digit(4'($urandom));
                    else if ($urandom_range(3) == 0)
                        buf_text.push_back(htfd_pkg::CH_SPACE);
                end
                default: begin
                    buf_text.push_back(htfd_pkg::CH_CLOSE);
                end
            endcase
            // anything after a finished or aborted frame is dropped by the block
            if (shape != SHAPE_OPEN_END)
                repeat ($urandom_range(2))
                    buf_text.push_back(8'($urandom));
        end
        flush_buffer();
    endtask

    // random buffers until the send queue holds the requested number of items
    task automatic add_random_part(input int upto);
        int r;
        // each stretch opens with a frame that runs past the byte limit
        add_buffer(SHAPE_LONG, MAX_FRAME_BYTES + 1);
        while (tx_chars.size() < upto) begin
            r = $urandom_range(99);
            if (r < 45)
                add_buffer(SHAPE_GOOD, $urandom_range(6));
            else if (r < 55)
                add_buffer(SHAPE_HALF, $urandom_range(6));
            else if (r < 70)
                add_buffer(SHAPE_BADCHAR, $urandom_range(6));
            else if (r < 83)
                add_buffer(SHAPE_OPEN_END, $urandom_range(6));
            else if (r < 97)
                add_buffer(SHAPE_NOISE, 0);
            else
                add_buffer(SHAPE_LONG, $urandom_range(MAX_FRAME_BYTES + 2,
                                                      MAX_FRAME_BYTES - 2));
        end
    endtask

    // ---------------- idling ----------------

    // sender idles 27 / receiver 54, then swapped, then no idling at all
    function automatic int tx_idle_pct();
        if (in_count < mode_edge1)
            return 27;
        if (in_count < mode_edge2)
            return 54;
        return 0;
    endfunction

    function automatic int rx_idle_pct();
        if (in_count < mode_edge1)
            return 54;
        if (in_count < mode_edge2)
            return 27;
        return 0;
    endfunction

    // one long receiver hold-off early in the run, the result queue backs up into s_ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (!hold_done && in_count >= HOLD_AT_ITEM) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // sender: a new item only once the current one is taken, never idles during the hold
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (tx_chars.size() > 0 &&
                (hold_left != 0 || $urandom_range(99) >= tx_idle_pct())) begin
                s_valid <= 1'b1;
                s_data  <= tx_chars.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct());
    end

    // ---------------- prediction and checking ----------------

    task automatic report_mismatch(input string what, input htfd_pkg::out_item_t exp_r,
                                   input htfd_pkg::out_item_t got_r);
        err_count++;
        if (err_count <= 10)
            $display("%0t: %s: expected kind %0d byte %02h len %0d last %0b, ",
                     $realtime, what, exp_r.kind, exp_r.byte_value, exp_r.frame_length,
                     exp_r.last_of_run,
                     "got kind %0d byte %02h len %0d last %0b",
                     got_r.kind, got_r.byte_value, got_r.frame_length,
                     got_r.last_of_run);
    endtask

    // predict on every accepted item first, then check any accepted result
    always @(posedge aclk) begin
        if (!aresetn) begin
            frame_phase = htfd_pkg::PH_AWAIT;
            clear_frame();
        end else begin
            if (s_valid && s_ready) begin
                decode_char(s_data);
                in_count <= in_count + 1;
            end
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    report_mismatch("unexpected result", '0, m_data);
                end else begin
                    want = due_results.pop_front();
                    if (m_data.kind !== want.kind ||
                        m_data.byte_value !== want.byte_value ||
                        m_data.frame_length !== want.frame_length ||
                        m_data.last_of_run !== want.last_of_run)
                        report_mismatch("result mismatch", want, m_data);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("hex_text_frame_decoder regression: fail");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial begin
        // directed buffers
        add_text("x");              // bad first character
        add_text("[");              // open bracket alone, buffer ends in frame
        add_text("[]");             // empty frame
        add_text("[ 0 Fa]");        // space inside a pair, half pair dropped at close
        add_text("[fF");            // last item completes a byte: data then unterminated
        add_text("[z1]");           // stray character, rest ignored
        add_text("[", 8'hFF, 1'b1); // top character value aborts the frame
        add_text("", 8'h00, 1'b1);  // zero character as first of a buffer
        add_text("[9a Bc]");        // mixed case digits

        add_random_part(tx_chars.size() + MODE_ITEMS);
        mode_edge1 = tx_chars.size();
        add_random_part(tx_chars.size() + MODE_ITEMS);
        mode_edge2 = tx_chars.size();
        add_random_part(tx_chars.size() + MODE_ITEMS);
        total_chars = tx_chars.size();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // all items in, then all owed results out, then a short drain
        while (in_count < total_chars)
            @(posedge aclk);
        while (due_results.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (err_count == 0)
            $display("hex_text_frame_decoder regression: pass");
        else
            $display("hex_text_frame_decoder regression: fail");
        $finish;
    end

endmodule
